FILE: rtl/core/sfq_pkg.sv
// sfq_pkg: shared types and constants of the searchable fifo queue
// used by sfq_ctrl, sfq_datapath and searchable_fifo_queue; no dependencies
`default_nettype none

package sfq_pkg;

  // default sizes and fixed port field widths
  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefWordBits  = 32;
  localparam int unsigned FieldBits    = 32;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ_WAIT,
    S_SEARCH
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    enqueue;
    logic    dequeue;
    logic    walk_start;
    logic    walk_step;
    logic    front_load;
    logic    hit_load;
    logic    status_load;
    status_e status;
    logic    report;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfq_datapath.sv
// sfq_datapath: entry memory, queue pointers, search walk and result registers
// depends on sfq_pkg for the command and status structs
`default_nettype none

module sfq_datapath import sfq_pkg::*; #(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned WORD_BITS = DefWordBits,
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  cmd_t                       cmd_i,
  output dp_stat_t                   stat_o,
  input  wire [1:0]                  operation_i,
  input  wire signed [FieldBits-1:0] push_value_i,
  input  wire signed [FieldBits-1:0] search_key_i,
  output logic                       strobe_o,
  output logic [1:0]                 status_o,
  output logic                       was_empty_o,
  output logic [CntW-1:0]            position_o,
  output logic signed [FieldBits-1:0] front_word_o,
  output logic signed [FieldBits-1:0] back_word_o,
  output logic                       empty_flag_o,
  output logic                       full_flag_o,
  output logic [CntW-1:0]            occupancy_o
);

  // entry memory, undefined until written
  logic signed [WORD_BITS-1:0] mem_q [CAPACITY];

  logic [IdxW-1:0]            head_q, tail_q, ptr_q, chk_q;
  logic [CntW-1:0]            count_q, position_q;
  logic signed [WORD_BITS-1:0] push_q, key_q, front_q, back_q, rd_q;
  op_e                        op_q;
  status_e                    status_q;
  logic                       was_empty_q, strobe_q;
  logic                       rd_en;
  logic [IdxW-1:0]            rd_addr, head_nxt;
  logic                       empty, full;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    idx_inc = (i == IdxW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  assign empty    = (count_q == '0);
  assign full     = (count_q == CntW'(CAPACITY));
  assign head_nxt = idx_inc(head_q);

  // memory read port select
  always_comb begin
    rd_en   = cmd_i.dequeue | cmd_i.walk_start | cmd_i.walk_step;
    rd_addr = ptr_q;
    if (cmd_i.dequeue) begin
      rd_addr = head_nxt;
    end else if (cmd_i.walk_start) begin
      rd_addr = head_q;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.enqueue) begin
      mem_q[tail_q] <= push_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // queue pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.report;
      if (cmd_i.enqueue) begin
        tail_q  <= idx_inc(tail_q);
        count_q <= count_q + 1'b1;
      end else if (cmd_i.dequeue) begin
        head_q  <= head_nxt;
        count_q <= count_q - 1'b1;
      end
    end
  end

  // request capture, end words, search walk and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= op_e'(operation_i);
      push_q      <= WORD_BITS'(push_value_i);
      key_q       <= WORD_BITS'(search_key_i);
      was_empty_q <= 1'b0;
      position_q  <= '0;
    end
    if (cmd_i.enqueue) begin
      was_empty_q <= empty;
      back_q      <= push_q;
      if (empty) begin
        front_q <= push_q;
      end
    end
    if (cmd_i.front_load) begin
      front_q <= rd_q;
    end
    if (cmd_i.walk_start) begin
      ptr_q <= head_nxt;
      chk_q <= '0;
    end else if (cmd_i.walk_step) begin
      ptr_q <= idx_inc(ptr_q);
      chk_q <= chk_q + 1'b1;
    end
    if (cmd_i.hit_load) begin
      position_q <= CntW'(chk_q) + 1'b1;
    end
    if (cmd_i.status_load) begin
      status_q <= cmd_i.status;
    end
  end

  // status to the controller
  assign stat_o.op    = op_q;
  assign stat_o.empty = empty;
  assign stat_o.full  = full;
  assign stat_o.hit   = (rd_q == key_q);
  assign stat_o.last  = ((CntW'(chk_q) + 1'b1) == count_q);

  // result ports, driven from registers
  assign strobe_o     = strobe_q;
  assign status_o     = status_q;
  assign was_empty_o  = was_empty_q;
  assign position_o   = position_q;
  assign front_word_o = empty ? '1 : FieldBits'(front_q);
  assign back_word_o  = empty ? '1 : FieldBits'(back_q);
  assign empty_flag_o = empty;
  assign full_flag_o  = full;
  assign occupancy_o  = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/sfq_ctrl.sv
// sfq_ctrl: request sequencer of the searchable fifo queue
// depends on sfq_pkg for states, codes and the command and status structs
`default_nettype none

module sfq_ctrl import sfq_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      start_i,
  output logic     busy_o,
  input  dp_stat_t stat_i,
  output cmd_t     cmd_o,
  output state_e   state_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_DEQUEUE: state_d = stat_i.empty ? S_IDLE : S_DEQ_WAIT;
          OP_SEARCH:  state_d = stat_i.empty ? S_IDLE : S_SEARCH;
          default:    state_d = S_IDLE;
        endcase
      end
      S_DEQ_WAIT: state_d = S_IDLE;
      S_SEARCH: begin
        if (stat_i.hit || stat_i.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = STAT_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = start_i;
      end
      S_EXEC: begin
        cmd_o.status_load = 1'b1;
        case (stat_i.op)
          OP_ENQUEUE: begin
            cmd_o.report = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = STAT_OVERFLOW;
            end else begin
              cmd_o.enqueue = 1'b1;
            end
          end
          OP_DEQUEUE: begin
            if (stat_i.empty) begin
              cmd_o.status = STAT_UNDERFLOW;
              cmd_o.report = 1'b1;
            end else begin
              cmd_o.dequeue = 1'b1;
            end
          end
          OP_SEARCH: begin
            if (stat_i.empty) begin
              cmd_o.status = STAT_NOT_FOUND;
              cmd_o.report = 1'b1;
            end else begin
              cmd_o.walk_start = 1'b1;
            end
          end
          default: begin
            cmd_o.report = 1'b1;
          end
        endcase
      end
      S_DEQ_WAIT: begin
        cmd_o.front_load = 1'b1;
        cmd_o.report     = 1'b1;
      end
      S_SEARCH: begin
        if (stat_i.hit) begin
          cmd_o.hit_load    = 1'b1;
          cmd_o.status_load = 1'b1;
          cmd_o.report      = 1'b1;
        end else if (stat_i.last) begin
          cmd_o.status      = STAT_NOT_FOUND;
          cmd_o.status_load = 1'b1;
          cmd_o.report      = 1'b1;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o  = (state_q != S_IDLE);
  assign state_o = state_q;

endmodule

`default_nettype wire

FILE: rtl/core/searchable_fifo_queue.sv
// searchable_fifo_queue: bounded fifo of signed words with key search
// dequeue waits for the new front word, search walks from the head to a hit or the last
// entry; the next request is taken at the result edge
// reset (async, active low) empties the queue; entry memory is left uninitialized
// one request at a time and the receiver cannot stall
// depends on sfq_pkg, sfq_ctrl and sfq_datapath
`default_nettype none

module searchable_fifo_queue import sfq_pkg::*; #(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned WORD_BITS = DefWordBits,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire [1:0]                   operation_i,
  input  wire signed [FieldBits-1:0]  push_value_i,
  input  wire signed [FieldBits-1:0]  search_key_i,
  output logic                        strobe_o,
  output logic [1:0]                  status_o,
  output logic                        was_empty_o,
  output logic [CntW-1:0]             position_o,
  output logic signed [FieldBits-1:0] front_word_o,
  output logic signed [FieldBits-1:0] back_word_o,
  output logic                        empty_flag_o,
  output logic                        full_flag_o,
  output logic [CntW-1:0]             occupancy_o
);

  cmd_t     cmd;
  dp_stat_t dp_stat;
  state_e   state;

  // request sequencer
  sfq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (dp_stat),
    .cmd_o   (cmd),
    .state_o (state)
  );

  // storage and walk datapath
  sfq_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (dp_stat),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .search_key_i (search_key_i),
    .strobe_o     (strobe_o),
    .status_o     (status_o),
    .was_empty_o  (was_empty_o),
    .position_o   (position_o),
    .front_word_o (front_word_o),
    .back_word_o  (back_word_o),
    .empty_flag_o (empty_flag_o),
    .full_flag_o  (full_flag_o),
    .occupancy_o  (occupancy_o)
  );

`ifndef ASSERT_OFF
  // occupancy never passes capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_o <= CntW'(CAPACITY))
    else $error("occupancy above capacity");

  // a result is only reported once the sequencer is back to idle
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (state == S_IDLE))
    else $error("result strobe while busy");

  // an accepted request makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but not busy");

  // overflow only reported on a full queue
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o == STAT_OVERFLOW) |-> full_flag_o)
    else $error("overflow reported on a queue that is not full");

  // a search hit lands within the occupied entries
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && position_o != '0) |-> (position_o <= occupancy_o))
    else $error("search position beyond occupancy");
`endif

endmodule

`default_nettype wire

FILE: bench/sfq_result_checker.sv
// sfq_result_checker: watches the request and result ports of the searchable fifo queue,
// keeps a shadow copy of the queue, and compares every result with its prediction
// depends on sfq_pkg
`timescale 1ns / 100ps

module sfq_result_checker import sfq_pkg::*; #(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned WORD_BITS = DefWordBits,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire                        busy_i,
  input  wire [1:0]                  operation_i,
  input  wire [FieldBits-1:0]        push_value_i,
  input  wire [FieldBits-1:0]        search_key_i,
  input  wire                        strobe_i,
  input  wire [1:0]                  status_i,
  input  wire                        was_empty_i,
  input  wire [CntW-1:0]             position_i,
  input  wire signed [FieldBits-1:0] front_word_i,
  input  wire signed [FieldBits-1:0] back_word_i,
  input  wire                        empty_flag_i,
  input  wire                        full_flag_i,
  input  wire [CntW-1:0]             occupancy_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o,
  output int                         overflow_o,
  output int                         underflow_o,
  output int                         search_hit_o
);

  // one predicted result
  typedef struct {
    status_e                     status;
    logic                        was_empty;
    logic [CntW-1:0]             position;
    logic signed [FieldBits-1:0] front_word;
    logic signed [FieldBits-1:0] back_word;
    logic                        empty_flag;
    logic                        full_flag;
    logic [CntW-1:0]             occupancy;
  } queue_result_t;

  // shadow queue
  logic [WORD_BITS-1:0] shadow_words [CAPACITY];
  int unsigned          shadow_head;
  int unsigned          shadow_tail;
  int unsigned          shadow_count;

  queue_result_t expected_results [$];
  queue_result_t oldest_result;

  int mismatch_total = 0;
  int checked_total  = 0;
  int overflow_total = 0;
  int underflow_total = 0;
  int hit_total      = 0;

  // stored word as shown on the ports: sign extended from the word width
  function automatic logic signed [FieldBits-1:0] shown_word(logic [WORD_BITS-1:0] w);
    return FieldBits'(signed'(w));
  endfunction

  function automatic int unsigned wrap_next(int unsigned idx);
    return (idx + 1 >= CAPACITY) ? 0 : idx + 1;
  endfunction

  // apply one request to the shadow queue and queue up the result it should give
  task automatic predict_queue_result(input op_e op, input logic [FieldBits-1:0] push_word,
                                      input logic [FieldBits-1:0] key_word);
    queue_result_t        res;
    int unsigned          idx;
    int unsigned          last;
    logic [WORD_BITS-1:0] key_bits;
    res.status     = STAT_OK;
    res.was_empty  = 1'b0;
    res.position   = '0;
    res.front_word = -1;
    res.back_word  = -1;
    key_bits = WORD_BITS'(signed'(key_word));
    case (op)
      OP_ENQUEUE: begin
        if (shadow_count >= CAPACITY) begin
          res.status = STAT_OVERFLOW;
          overflow_total++;
        end else begin
          res.was_empty = (shadow_count == 0);
          shadow_words[shadow_tail] = WORD_BITS'(signed'(push_word));
          shadow_tail = wrap_next(shadow_tail);
          shadow_count++;
        end
      end
      OP_DEQUEUE: begin
        if (shadow_count == 0) begin
          res.status = STAT_UNDERFLOW;
          underflow_total++;
        end else begin
          shadow_head = wrap_next(shadow_head);
          shadow_count--;
        end
      end
      OP_SEARCH: begin
        // oldest match wins
        idx = shadow_head;
        for (int i = 0; i < shadow_count && res.position == 0; i++) begin
          if (shadow_words[idx] == key_bits) res.position = CntW'(i + 1);
          idx = wrap_next(idx);
        end
        if (res.position == 0) res.status = STAT_NOT_FOUND;
        else hit_total++;
      end
      default: begin
        // no-op request only reports the queue
      end
    endcase
    if (shadow_count != 0) begin
      last = (shadow_tail == 0) ? CAPACITY - 1 : shadow_tail - 1;
      res.front_word = shown_word(shadow_words[shadow_head]);
      res.back_word  = shown_word(shadow_words[last]);
    end
    res.empty_flag = (shadow_count == 0);
    res.full_flag  = (shadow_count >= CAPACITY);
    res.occupancy  = CntW'(shadow_count);
    expected_results.push_back(res);
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_total++;
    end
  endtask

  // results first, then the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_head  = 0;
      shadow_tail  = 0;
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (strobe_i) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatch_total++;
        end else begin
          oldest_result = expected_results.pop_front();
          compare_field("status",     oldest_result.status,     status_i);
          compare_field("was_empty",  oldest_result.was_empty,  was_empty_i);
          compare_field("position",   oldest_result.position,   position_i);
          compare_field("front_word", oldest_result.front_word, front_word_i);
          compare_field("back_word",  oldest_result.back_word,  back_word_i);
          compare_field("empty_flag", oldest_result.empty_flag, empty_flag_i);
          compare_field("full_flag",  oldest_result.full_flag,  full_flag_i);
          compare_field("occupancy",  oldest_result.occupancy,  occupancy_i);
          checked_total++;
        end
      end
      if (start_i && !busy_i) begin
        predict_queue_result(op_e'(operation_i), push_value_i, search_key_i);
      end
    end
    fail_count_o <= mismatch_total;
    pending_o    <= expected_results.size();
    checked_o    <= checked_total;
    overflow_o   <= overflow_total;
    underflow_o  <= underflow_total;
    search_hit_o <= hit_total;
  end

endmodule

FILE: bench/tb_searchable_fifo_queue.sv
// tb_searchable_fifo_queue: request stimulus and verdict for the searchable fifo queue
// depends on sfq_pkg, searchable_fifo_queue and sfq_result_checker
`timescale 1ns / 100ps

module tb_searchable_fifo_queue;
  import sfq_pkg::*;

  localparam int unsigned CntW = $clog2(DefCapacity + 1);
  localparam int unsigned RandomRequests = 1000;

  // operation mixes of the random segments
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN,
    MIX_SEARCH
  } mix_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  operation_i = OP_NOP;
  logic [FieldBits-1:0]        push_value_i = '0;
  logic [FieldBits-1:0]        search_key_i = '0;
  logic                        strobe_o;
  logic [1:0]                  status_o;
  logic                        was_empty_o;
  logic [CntW-1:0]             position_o;
  logic signed [FieldBits-1:0] front_word_o;
  logic signed [FieldBits-1:0] back_word_o;
  logic                        empty_flag_o;
  logic                        full_flag_o;
  logic [CntW-1:0]             occupancy_o;

  int fail_count;
  int pending;
  int checked;
  int overflows;
  int underflows;
  int search_hits;

  int             requests_sent = 0;
  logic           back_to_back = 1'b0;
  logic [31:0]    word_pool [8];

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  searchable_fifo_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .push_value_i(push_value_i),
    .search_key_i(search_key_i),
    .strobe_o    (strobe_o),
    .status_o    (status_o),
    .was_empty_o (was_empty_o),
    .position_o  (position_o),
    .front_word_o(front_word_o),
    .back_word_o (back_word_o),
    .empty_flag_o(empty_flag_o),
    .full_flag_o (full_flag_o),
    .occupancy_o (occupancy_o)
  );

  sfq_result_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .operation_i (operation_i),
    .push_value_i(push_value_i),
    .search_key_i(search_key_i),
    .strobe_i    (strobe_o),
    .status_i    (status_o),
    .was_empty_i (was_empty_o),
    .position_i  (position_o),
    .front_word_i(front_word_o),
    .back_word_i (back_word_o),
    .empty_flag_i(empty_flag_o),
    .full_flag_i (full_flag_o),
    .occupancy_i (occupancy_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .overflow_o  (overflows),
    .underflow_o (underflows),
    .search_hit_o(search_hits)
  );

  // issue one request and return at the edge that takes it
  task automatic send_request(input op_e op, input logic [31:0] push_word,
                              input logic [31:0] key_word);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    push_value_i <= push_word;
    search_key_i <= key_word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // reuse a small set of words half the time so searches hit and duplicates occur
  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic op_e pick_op(mix_e mix);
    int roll;
    int enq_pct;
    int deq_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   begin enq_pct = 65; deq_pct = 15; end
      MIX_DRAIN:  begin enq_pct = 15; deq_pct = 65; end
      MIX_SEARCH: begin enq_pct = 20; deq_pct = 15; end
      default:    begin enq_pct = 35; deq_pct = 30; end
    endcase
    if (roll < enq_pct) return OP_ENQUEUE;
    if (roll < enq_pct + deq_pct) return OP_DEQUEUE;
    if (roll < 95) return OP_SEARCH;
    return OP_NOP;
  endfunction

  // stimulus
  initial begin
    int   seg;
    int   seg_len;
    mix_e mix;
    word_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0000_0001, $urandom, $urandom, $urandom};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue corner cases
    send_request(OP_DEQUEUE, 32'h0, 32'h0);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill to capacity with extreme and patterned words
    send_request(OP_ENQUEUE, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_ENQUEUE, 32'h0000_0000, 32'h0);
    send_request(OP_ENQUEUE, 32'h0000_0001, 32'h0);
    send_request(OP_ENQUEUE, 32'hAAAA_AAAA, 32'h0);
    send_request(OP_ENQUEUE, 32'h5555_5555, 32'h0);
    for (int i = 7; i < DefCapacity; i++) send_request(OP_ENQUEUE, 32'h0101_0101 * i, 32'h0);
    // full queue: overflow, first and last hit, miss, no-op, then one dequeue
    send_request(OP_ENQUEUE, 32'hDEAD_BEEF, 32'h0);
    send_request(OP_SEARCH, 32'h0, 32'h8000_0000);
    send_request(OP_SEARCH, 32'h0, 32'h0101_0101 * (DefCapacity - 1));
    send_request(OP_SEARCH, 32'h0, 32'h1234_5678);
    send_request(OP_NOP, 32'h0, 32'h0);
    send_request(OP_DEQUEUE, 32'h0, 32'h0);
    wait_drained();

    // random segments, each with its own operation mix and idling style
    seg = 0;
    while (requests_sent < RandomRequests + 25) begin
      seg_len      = $urandom_range(20, 60);
      mix          = mix_e'($urandom_range(0, 3));
      back_to_back = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        send_request(pick_op(mix), pick_word(), pick_word());
      end
      if (seg == 2 || $urandom_range(0, 3) == 0) wait_drained();
      seg++;
    end

    // drain and let the last search walk finish
    wait_drained();
    repeat (DefCapacity + 4) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results", requests_sent, checked);
    $display("saw %0d overflows, %0d underflows, %0d search hits",
             overflows, underflows, search_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("searchable_fifo_queue test passed");
    end else begin
      $display("searchable_fifo_queue test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("searchable_fifo_queue test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sfq_pkg.sv
rtl/core/sfq_datapath.sv
rtl/core/sfq_ctrl.sv
rtl/core/searchable_fifo_queue.sv
bench/sfq_result_checker.sv
bench/tb_searchable_fifo_queue.sv
